/* hdl/grt_pkg.sv */
// Shared types and constants for the generation retire tracker.
package grt_pkg;

  localparam logic [1:0] MODE_PUBLISH  = 2'd0;
  localparam logic [1:0] MODE_RESOLVE  = 2'd1;
  localparam logic [1:0] MODE_COMPLETE = 2'd2;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_REJECT = 2'd1;
  localparam logic [1:0] STATUS_FULL   = 2'd2;

  localparam logic [31:0] SLOT_INDEX = 32'd1;

  // Depth of the command queue and of the result queue.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_PUBLISH,
    OP_RESOLVE,
    OP_COMPLETE,
    OP_BAD
  } op_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        program_valid;
    logic [31:0] handle_index;
    logic [31:0] handle_generation;
    logic [63:0] frame;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        has_entry;
    logic [31:0] out_index;
    logic [31:0] out_generation;
    logic [63:0] out_frame;
    logic        last;
  } res_t;

  // Classified command as it waits between front and back.
  typedef struct packed {
    op_t         op;
    logic        program_valid;
    logic        index_ok;
    logic        frame_zero;
    logic [31:0] handle_generation;
    logic [63:0] frame;
  } front_cmd_t;

endpackage

/* hdl/generation_retire_tracker.sv */
// Top level of the generation retire tracker: command queue, executor, result queue.
//
//   channel  | handshake          | payload          | direction
//   ---------+--------------------+------------------+----------
//   command  | push / full        | cmd    (cmd_t)   | in
//   result   | pop / empty        | result (res_t)   | out
//
// Publish, resolve, rejected commands and completes on an empty list are handled in ST_IDLE.
// Complete with pending entries starts in ST_IDLE, does one pending-list RAM read per
// cycle through ST_WALK unless a full result queue stalls it, then ends in ST_FINISH.
// Reset (rst, synchronous) empties both queues and clears tracker state but held_gen/held_frame.
// A full result queue stalls the executor; the two-entry command queue keeps
// accepting items meanwhile, and full rises only once it holds two.
module generation_retire_tracker
  import grt_pkg::*;
#(
  parameter int PENDING_DEPTH = 16,
  parameter int GEN_BITS      = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  cmd_t cmd,
  output logic empty,
  input  logic pop,
  output res_t result
);

  // Classified command at the head of the command queue.
  logic       head_valid;
  front_cmd_t head;
  logic       take;

  // Accept and classify items.
  grt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .cmd        (cmd),
    .head_valid (head_valid),
    .head       (head),
    .take       (take)
  );

  // Execute commands, walk the pending list, queue results.
  grt_back #(
    .PENDING_DEPTH (PENDING_DEPTH),
    .GEN_BITS      (GEN_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .take       (take),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

endmodule

/* hdl/grt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module grt_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/grt_front.sv */
// Front end: command queue that accepts items and classifies them.
module grt_front
  import grt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  cmd_t       cmd,
  output logic       head_valid,
  output front_cmd_t head,
  input  logic       take
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  front_cmd_t     slots [QUEUE_DEPTH];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [CW-1:0]  count;
  front_cmd_t     classified;
  logic           do_push;
  logic           do_take;

  always_comb begin
    classified                   = '0;
    classified.program_valid     = cmd.program_valid;
    classified.index_ok          = (cmd.handle_index == SLOT_INDEX);
    classified.frame_zero        = (cmd.frame == 64'd0);
    classified.handle_generation = cmd.handle_generation;
    classified.frame             = cmd.frame;
    unique case (cmd.mode)
      MODE_PUBLISH:  classified.op = OP_PUBLISH;
      MODE_RESOLVE:  classified.op = OP_RESOLVE;
      MODE_COMPLETE: classified.op = OP_COMPLETE;
      default:       classified.op = OP_BAD;
    endcase
  end

  assign full       = (count == CW'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_take    = take && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= classified;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + CW'(do_push) - CW'(do_take);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("command queue overfilled");
`endif

endmodule

/* hdl/grt_back.sv */
// Back end: executes commands against the generation state and pending list.
module grt_back
  import grt_pkg::*;
#(
  parameter int PENDING_DEPTH = 16,
  parameter int GEN_BITS      = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  front_cmd_t head,
  output logic       take,
  input  logic       pop,
  output logic       empty,
  output res_t       result
);

  localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
  localparam int CMP_W = (GEN_BITS > 32) ? GEN_BITS : 32;
  localparam int ENT_W = GEN_BITS + 64;
  localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_t;

  state_t              state, state_next;
  logic                present, present_next;
  logic [GEN_BITS-1:0] current_gen, current_gen_next;
  logic [63:0]         current_last_use, current_last_use_next;
  logic [63:0]         completed_through, completed_through_next;
  logic [63:0]         last_recorded, last_recorded_next;
  logic [CNT_W-1:0]    pending_count, pending_count_next;
  logic [IDX_W-1:0]    walk_idx, walk_idx_next;
  logic [CNT_W-1:0]    keep, keep_next;
  logic                held_valid, held_valid_next;
  logic [GEN_BITS-1:0] held_gen, held_gen_next;
  logic [63:0]         held_frame, held_frame_next;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [ENT_W-1:0]    ram_wdata;
  logic                ram_re;
  logic [IDX_W-1:0]    ram_raddr;
  logic [ENT_W-1:0]    ram_rdata;

  logic [GEN_BITS-1:0] ent_gen;
  logic [63:0]         ent_last_use;
  logic                ent_retire;
  logic                ent_final;
  logic                advance;

  res_t                res_new;
  logic                res_push;
  logic                space;
  res_t                outq [QUEUE_DEPTH];
  logic                oq_wr;
  logic                oq_rd;
  logic [QC_W-1:0]     oq_count;
  logic                oq_pop;

  grt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (PENDING_DEPTH)
  ) u_pending (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign space        = (oq_count != QC_W'(QUEUE_DEPTH));
  assign ent_gen      = ram_rdata[ENT_W-1:64];
  assign ent_last_use = ram_rdata[63:0];
  assign ent_retire   = (ent_last_use <= head.frame);
  assign ent_final    = ((CNT_W'(walk_idx) + CNT_W'(1)) == pending_count);
  assign advance      = !(ent_retire && held_valid) || space;

  always_comb begin
    state_next             = state;
    present_next           = present;
    current_gen_next       = current_gen;
    current_last_use_next  = current_last_use;
    completed_through_next = completed_through;
    last_recorded_next     = last_recorded;
    pending_count_next     = pending_count;
    walk_idx_next          = walk_idx;
    keep_next              = keep;
    held_valid_next        = held_valid;
    held_gen_next          = held_gen;
    held_frame_next        = held_frame;
    ram_we                 = 1'b0;
    ram_waddr              = pending_count[IDX_W-1:0];
    ram_wdata              = {current_gen, current_last_use};
    ram_re                 = 1'b0;
    ram_raddr              = '0;
    take                   = 1'b0;
    res_push               = 1'b0;
    res_new                = '0;
    res_new.status         = STATUS_OK;
    res_new.last           = 1'b1;

    unique case (state)
      ST_IDLE: begin
        if (head_valid && space) begin
          unique case (head.op)
            OP_PUBLISH: begin
              take     = 1'b1;
              res_push = 1'b1;
              if (!head.program_valid) begin
                res_new.status = STATUS_REJECT;
              end else if (!present) begin
                present_next           = 1'b1;
                current_gen_next       = GEN_BITS'(1);
                current_last_use_next  = '0;
                res_new.has_entry      = 1'b1;
                res_new.out_index      = SLOT_INDEX;
                res_new.out_generation = 32'd1;
              end else if (&current_gen) begin
                res_new.status = STATUS_REJECT;
              end else if (pending_count == CNT_W'(PENDING_DEPTH)) begin
                res_new.status = STATUS_FULL;
              end else begin
                // Push the current generation onto the pending list.
                ram_we                 = 1'b1;
                pending_count_next     = pending_count + CNT_W'(1);
                current_gen_next       = current_gen + GEN_BITS'(1);
                current_last_use_next  = '0;
                res_new.has_entry      = 1'b1;
                res_new.out_index      = SLOT_INDEX;
                res_new.out_generation = 32'(current_gen + GEN_BITS'(1));
              end
            end
            OP_RESOLVE: begin
              take     = 1'b1;
              res_push = 1'b1;
              if (!present || !head.index_ok ||
                  CMP_W'(head.handle_generation) != CMP_W'(current_gen) ||
                  head.frame_zero || head.frame <= completed_through ||
                  head.frame < last_recorded) begin
                res_new.status = STATUS_REJECT;
              end else begin
                if (head.frame > current_last_use) begin
                  current_last_use_next = head.frame;
                end
                last_recorded_next     = head.frame;
                res_new.has_entry      = 1'b1;
                res_new.out_index      = SLOT_INDEX;
                res_new.out_generation = head.handle_generation;
                res_new.out_frame      = head.frame;
              end
            end
            OP_COMPLETE: begin
              if (head.frame_zero || head.frame < completed_through) begin
                take           = 1'b1;
                res_push       = 1'b1;
                res_new.status = STATUS_REJECT;
              end else if (pending_count == '0) begin
                take                   = 1'b1;
                res_push               = 1'b1;
                completed_through_next = head.frame;
              end else begin
                // Start the walk: fetch entry 0, its data shows up in ST_WALK.
                ram_re          = 1'b1;
                ram_raddr       = '0;
                walk_idx_next   = '0;
                keep_next       = '0;
                held_valid_next = 1'b0;
                state_next      = ST_WALK;
              end
            end
            default: begin
              take           = 1'b1;
              res_push       = 1'b1;
              res_new.status = STATUS_REJECT;
            end
          endcase
        end
      end

      ST_WALK: begin
        if (advance) begin
          if (ent_retire) begin
            // Emit the previously held retirement; hold this one.
            if (held_valid) begin
              res_push               = 1'b1;
              res_new.has_entry      = 1'b1;
              res_new.out_index      = SLOT_INDEX;
              res_new.out_generation = 32'(held_gen);
              res_new.out_frame      = held_frame;
              res_new.last           = 1'b0;
            end
            held_valid_next = 1'b1;
            held_gen_next   = ent_gen;
            held_frame_next = ent_last_use;
          end else begin
            // Compact the kept entry toward the head of the list.
            ram_we    = 1'b1;
            ram_waddr = keep[IDX_W-1:0];
            ram_wdata = ram_rdata;
            keep_next = keep + CNT_W'(1);
          end
          if (ent_final) begin
            state_next = ST_FINISH;
          end else begin
            walk_idx_next = walk_idx + IDX_W'(1);
            ram_re        = 1'b1;
            ram_raddr     = walk_idx + IDX_W'(1);
          end
        end
      end

      ST_FINISH: begin
        if (space) begin
          res_push = 1'b1;
          if (held_valid) begin
            res_new.has_entry      = 1'b1;
            res_new.out_index      = SLOT_INDEX;
            res_new.out_generation = 32'(held_gen);
            res_new.out_frame      = held_frame;
          end
          pending_count_next     = keep;
          completed_through_next = head.frame;
          held_valid_next        = 1'b0;
          take                   = 1'b1;
          state_next             = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    held_gen   <= held_gen_next;
    held_frame <= held_frame_next;
    if (rst) begin
      state             <= ST_IDLE;
      present           <= 1'b0;
      current_gen       <= '0;
      current_last_use  <= '0;
      completed_through <= '0;
      last_recorded     <= '0;
      pending_count     <= '0;
      walk_idx          <= '0;
      keep              <= '0;
      held_valid        <= 1'b0;
    end else begin
      state             <= state_next;
      present           <= present_next;
      current_gen       <= current_gen_next;
      current_last_use  <= current_last_use_next;
      completed_through <= completed_through_next;
      last_recorded     <= last_recorded_next;
      pending_count     <= pending_count_next;
      walk_idx          <= walk_idx_next;
      keep              <= keep_next;
      held_valid        <= held_valid_next;
    end
  end

  // Result queue.
  assign oq_pop = pop && (oq_count != '0);
  assign empty  = (oq_count == '0);
  assign result = outq[oq_rd];

  always_ff @(posedge clk) begin
    if (res_push) begin
      outq[oq_wr] <= res_new;
    end
    if (rst) begin
      oq_wr    <= 1'b0;
      oq_rd    <= 1'b0;
      oq_count <= '0;
    end else begin
      if (res_push) begin
        oq_wr <= ~oq_wr;
      end
      if (oq_pop) begin
        oq_rd <= ~oq_rd;
      end
      oq_count <= oq_count + QC_W'(res_push) - QC_W'(oq_pop);
    end
  end

`ifndef SYNTHESIS
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending_count <= CNT_W'(PENDING_DEPTH))
    else $error("pending count beyond list depth");

  a_keep_behind_walk: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> keep <= CNT_W'(walk_idx))
    else $error("compaction write ahead of walk");

  a_write_behind_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && ram_we && ram_re) |-> ram_waddr < ram_raddr)
    else $error("compaction overwrites an unread entry");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    res_push |-> space)
    else $error("result pushed into a full queue");

  a_walk_holds_cmd: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> head_valid && head.op == OP_COMPLETE && !take)
    else $error("complete command lost during walk");
`endif

endmodule
